// ===== sv/assert_macros.svh =====
// assertion macros used by the port-level checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== sv/iff_pkg.sv =====
// types and constants of the integer field formatter
// no dependencies
`default_nettype none
package iff_pkg;
    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_OCT  = 3'd2;
    localparam logic [2:0] MODE_HEXL = 3'd3;
    localparam logic [2:0] MODE_HEXU = 3'd4;
    localparam logic [2:0] MODE_PTR  = 3'd5;

    localparam logic [1:0] SIZE_SHORT = 2'd1;
    localparam logic [1:0] SIZE_LONG  = 2'd2;

    localparam int ND_W = 5;
    localparam int CNT_W = 7;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    // emission sections in output order
    typedef enum logic [2:0] {
        SEC_LPAD = 3'd0,
        SEC_SIGN = 3'd1,
        SEC_PFX  = 3'd2,
        SEC_ZPAD = 3'd3,
        SEC_DIG  = 3'd4,
        SEC_RPAD = 3'd5
    } t_sec;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
        logic [2:0] sec;
        logic [CNT_W-1:0] idx;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic [CNT_W-1:0] n_lpad;
        logic [CNT_W-1:0] n_sign;
        logic [CNT_W-1:0] n_pfx;
        logic [CNT_W-1:0] n_zpad;
        logic [CNT_W-1:0] n_dig;
        logic [CNT_W-1:0] n_rpad;
    } t_stat;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) c = CH_ZERO + {4'd0, d};
        else if (upper) c = 8'h41 + {4'd0, d} - 8'd10;
        else c = 8'h61 + {4'd0, d} - 8'd10;
        return c;
    endfunction
endpackage
`default_nettype wire

// ===== sv/integer_field_formatter_unit.sv =====
// channel   direction  handshake
// request   in         start high while busy low
// result    out        o_valid strobe, one cycle, o_last on final character of an item
//
// busy stays high until the previous item has been emitted in full: first the digits
// are extracted, one per step for octal and hex and by double dabble, four value bits
// per step, for decimal, none when no digit is written; then the characters are sent.
// Reset is synchronous and clears only the sequencer; the receiver cannot stall.
// depends on iff_pkg, iff_ctrl, iff_datapath
`default_nettype none
module integer_field_formatter_unit import iff_pkg::*; #(
    parameter int MAX_OUT = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_mode,
    input  wire logic [63:0] i_value,
    input  wire logic [1:0]  i_size_mode,
    input  wire logic [6:0]  i_field_width,
    input  wire logic [5:0]  i_min_digits,
    input  wire logic        i_has_precision,
    input  wire logic        i_left_justify,
    input  wire logic        i_plus_sign,
    input  wire logic        i_space_sign,
    input  wire logic        i_alt_form,
    input  wire logic        i_zero_pad,
    output logic             o_valid,
    output logic [7:0]       o_out_char,
    output logic             o_last
);
    t_cmd  cmd;
    t_stat stat;

    iff_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_stat(stat), .o_cmd(cmd), .o_valid(o_valid)
    );

    iff_datapath #(.MAX_OUT(MAX_OUT)) u_dp (
        .i_clk(i_clk), .i_mode(i_mode), .i_value(i_value), .i_size_mode(i_size_mode),
        .i_field_width(i_field_width), .i_min_digits(i_min_digits),
        .i_has_precision(i_has_precision), .i_left_justify(i_left_justify),
        .i_plus_sign(i_plus_sign), .i_space_sign(i_space_sign),
        .i_alt_form(i_alt_form), .i_zero_pad(i_zero_pad),
        .i_cmd(cmd), .o_stat(stat), .o_out_char(o_out_char), .o_last(o_last)
    );
endmodule
`default_nettype wire

// ===== sv/iff_datapath.sv =====
// operand decode, digit extraction and field layout
// depends on iff_pkg
`default_nettype none
module iff_datapath import iff_pkg::*; #(
    parameter int MAX_OUT = 64
) (
    input  wire logic        i_clk,
    input  wire logic [2:0]  i_mode,
    input  wire logic [63:0] i_value,
    input  wire logic [1:0]  i_size_mode,
    input  wire logic [6:0]  i_field_width,
    input  wire logic [5:0]  i_min_digits,
    input  wire logic        i_has_precision,
    input  wire logic        i_left_justify,
    input  wire logic        i_plus_sign,
    input  wire logic        i_space_sign,
    input  wire logic        i_alt_form,
    input  wire logic        i_zero_pad,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    output logic [7:0]       o_out_char,
    output logic             o_last
);
    localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_OUT);
    localparam logic [2:0] BASE_DEC = 3'd0;
    localparam logic [2:0] BASE_OCT = 3'd1;
    localparam logic [2:0] BASE_HEX = 3'd2;

    logic [63:0] r_rem;
    logic [63:0] r_mag;
    logic [2:0]  r_base_sel;
    logic        r_upper;
    logic [7:0]  r_sign_ch;
    logic        r_has_sign, r_alt, r_hasp, r_left, r_zpad;
    logic [5:0]  r_prec;
    logic [6:0]  r_width;
    logic [3:0]  r_digits [24];
    logic [ND_W-1:0] r_nd;
    logic        r_done;

    // ------------- load decode
    logic [2:0]  mode;
    logic [63:0] mag;
    logic        neg, skind, upper, alt;
    logic [2:0]  bsel;
    logic [31:0] low;

    always_comb begin
        mode = (i_mode > MODE_PTR) ? MODE_UDEC : i_mode;
        low = i_value[31:0];
        neg = 1'b0;
        skind = 1'b0;
        upper = 1'b0;
        alt = i_alt_form;
        bsel = BASE_DEC;
        mag = 64'd0;
        case (mode)
            MODE_SDEC: begin
                skind = 1'b1;
                if (i_size_mode == SIZE_LONG) begin
                    neg = i_value[63];
                    mag = neg ? (64'd0 - i_value) : i_value;
                end else begin
                    neg = low[31];
                    mag = neg ? (64'h1_0000_0000 - {32'd0, low}) : {32'd0, low};
                end
            end
            MODE_PTR: begin
                skind = 1'b1;
                mag = i_value;
                bsel = BASE_HEX;
                alt = 1'b1;
            end
            default: begin
                if (i_size_mode == SIZE_LONG) mag = i_value;
                else if (i_size_mode == SIZE_SHORT) mag = {48'd0, i_value[15:0]};
                else mag = {32'd0, low};
                if (mode == MODE_OCT) bsel = BASE_OCT;
                else if (mode == MODE_HEXL) bsel = BASE_HEX;
                else if (mode == MODE_HEXU) begin
                    bsel = BASE_HEX;
                    upper = 1'b1;
                end
            end
        endcase
    end

    // ------------- octal and hex: one digit per step
    // decimal: double dabble, four value bits per step, 16 steps
    logic [3:0]  dig;
    logic [63:0] quo;
    logic [79:0] r_bcd;
    logic [3:0]  r_step;
    logic [79:0] bcd_nx;
    logic [63:0] rem_nx;
    logic [ND_W-1:0] nd_dec;

    always_comb begin
        dig = 4'd0;
        quo = r_rem;
        if (r_base_sel == BASE_OCT) begin
            dig = {1'b0, r_rem[2:0]};
            quo = r_rem >> 3;
        end else if (r_base_sel == BASE_HEX) begin
            dig = r_rem[3:0];
            quo = r_rem >> 4;
        end
    end

    always_comb begin
        bcd_nx = r_bcd;
        rem_nx = r_rem;
        for (int s = 0; s < 4; s++) begin
            for (int j = 0; j < 20; j++) begin
                if (bcd_nx[4*j +: 4] >= 4'd5) bcd_nx[4*j +: 4] = bcd_nx[4*j +: 4] + 4'd3;
            end
            bcd_nx = {bcd_nx[78:0], rem_nx[63]};
            rem_nx = {rem_nx[62:0], 1'b0};
        end
        nd_dec = ND_W'(1);
        for (int j = 1; j < 20; j++) begin
            if (bcd_nx[4*j +: 4] != 4'd0) nd_dec = ND_W'(j + 1);
        end
    end

    logic [ND_W-1:0] nd_inc;
    assign nd_inc = r_nd + ND_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= mag;
            r_mag <= mag;
            r_base_sel <= bsel;
            r_upper <= upper;
            r_alt <= alt;
            r_hasp <= i_has_precision;
            r_left <= i_left_justify;
            r_zpad <= i_zero_pad && !i_has_precision && !i_left_justify;
            r_prec <= i_min_digits;
            r_width <= (i_field_width > 7'(MAX_OUT)) ? 7'(MAX_OUT) : i_field_width;
            r_has_sign <= skind && (neg || i_plus_sign || i_space_sign);
            r_sign_ch <= neg ? CH_MINUS : (i_plus_sign ? CH_PLUS : CH_SPACE);
            r_nd <= '0;
            r_done <= (mag == 64'd0) && i_has_precision && (i_min_digits == 6'd0);
            r_bcd <= '0;
            r_step <= 4'd15;
        end else if (i_cmd.div_step && !r_done) begin
            if (r_base_sel != BASE_DEC) begin
                r_digits[r_nd] <= dig;
                r_nd <= nd_inc;
                r_rem <= quo;
                if (quo == 64'd0) r_done <= 1'b1;
            end else begin
                r_bcd <= bcd_nx;
                r_rem <= rem_nx;
                r_step <= r_step - 4'd1;
                if (r_step == 4'd0) begin
                    for (int j = 0; j < 20; j++) r_digits[j] <= bcd_nx[4*j +: 4];
                    r_nd <= nd_dec;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // ------------- layout
    logic [CNT_W-1:0] pz, pfx, sg, body, pad, ndx;
    logic [CNT_W:0] body_w;
    always_comb begin
        ndx = CNT_W'(r_nd);
        sg = r_has_sign ? CNT_W'(1) : '0;
        pz = '0;
        if (r_hasp && CNT_W'(r_prec) > ndx) pz = CNT_W'(r_prec) - ndx;
        if (r_base_sel == BASE_OCT && r_alt && pz == '0 && (r_mag != 64'd0 || r_nd == '0))
            pz = CNT_W'(1);
        pfx = (r_base_sel == BASE_HEX && r_alt && r_mag != 64'd0) ? CNT_W'(2) : '0;
        body_w = {1'b0, sg} + {1'b0, pfx} + {1'b0, pz} + {1'b0, ndx};
        if (body_w > {1'b0, MAXC}) begin
            pz = pz - CNT_W'(body_w - {1'b0, MAXC});
            body = MAXC;
        end else begin
            body = body_w[CNT_W-1:0];
        end
        pad = (r_width > body) ? (r_width - body) : '0;
        o_stat.div_done = r_done;
        o_stat.n_lpad = (!r_left && !r_zpad) ? pad : '0;
        o_stat.n_sign = sg;
        o_stat.n_pfx = pfx;
        o_stat.n_zpad = pz + (r_zpad ? pad : '0);
        o_stat.n_dig = ndx;
        o_stat.n_rpad = r_left ? pad : '0;
    end

    // ------------- character output register
    logic [7:0] ch;
    logic [ND_W-1:0] di;
    always_comb begin
        di = r_nd - ND_W'(1) - i_cmd.idx[ND_W-1:0];
        case (i_cmd.sec)
            SEC_SIGN: ch = r_sign_ch;
            SEC_PFX:  ch = (i_cmd.idx == '0) ? CH_ZERO : (r_upper ? 8'h58 : 8'h78);
            SEC_ZPAD: ch = CH_ZERO;
            SEC_DIG:  ch = digit_char(r_digits[di], r_upper);
            default:  ch = CH_SPACE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_out_char <= ch;
        o_last <= i_cmd.last;
    end
endmodule
`default_nettype wire

// ===== sv/iff_ctrl.sv =====
// sequencer: load, digit extraction, section-by-section emission
// depends on iff_pkg
`default_nettype none
module iff_ctrl import iff_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  t_stat     i_stat,
    output t_cmd      o_cmd,
    output logic      o_valid
);
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_EMIT = 4'b0100,
        ST_END  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [2:0] r_sec, n_sec;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic r_valid;

    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] rest;
    logic any_after;

    always_comb begin
        case (r_sec)
            SEC_LPAD: cnt = i_stat.n_lpad;
            SEC_SIGN: cnt = i_stat.n_sign;
            SEC_PFX:  cnt = i_stat.n_pfx;
            SEC_ZPAD: cnt = i_stat.n_zpad;
            SEC_DIG:  cnt = i_stat.n_dig;
            default:  cnt = i_stat.n_rpad;
        endcase
        any_after = 1'b0;
        if (r_sec < SEC_SIGN && i_stat.n_sign != '0) any_after = 1'b1;
        if (r_sec < SEC_PFX  && i_stat.n_pfx  != '0) any_after = 1'b1;
        if (r_sec < SEC_ZPAD && i_stat.n_zpad != '0) any_after = 1'b1;
        if (r_sec < SEC_DIG  && i_stat.n_dig  != '0) any_after = 1'b1;
        if (r_sec < SEC_RPAD && i_stat.n_rpad != '0) any_after = 1'b1;
        rest = cnt - r_idx;
    end

    always_comb begin
        n_state = r_state;
        n_sec = r_sec;
        n_idx = r_idx;
        o_cmd = '0;
        o_cmd.sec = r_sec;
        o_cmd.idx = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    o_cmd.div_step = 1'b0;
                    n_state = ST_EMIT;
                    n_sec = SEC_LPAD;
                    n_idx = '0;
                end
            end
            ST_EMIT: begin
                if (r_idx >= cnt) begin
                    if (r_sec == SEC_RPAD) n_state = ST_END;
                    else n_sec = r_sec + 3'd1;
                    n_idx = '0;
                end else begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = (rest == CNT_W'(1)) && !any_after;
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ST_END: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sec <= SEC_LPAD;
            r_idx <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sec <= n_sec;
            r_idx <= n_idx;
            r_valid <= o_cmd.emit;
        end
    end

    assign busy = (r_state != ST_IDLE) || r_valid;
    assign o_valid = r_valid;
endmodule
`default_nettype wire

// ===== sv/iff_checker.sv =====
// port-level checks of the formatter, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module iff_port_props (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid,
    input wire logic o_last
);
    `CHK_IMPL(a_valid_busy, i_clk, i_rst_n, o_valid, busy, "result while not busy")
    `CHK_IMPL(a_last_valid, i_clk, i_rst_n, o_last && o_valid, busy, "last without busy")
    `CHK_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "accept without busy")
    `CHK_NEXT(a_last_gap, i_clk, i_rst_n, o_valid && o_last, !o_valid, "item after last")
endmodule

bind integer_field_formatter_unit iff_port_props u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_last(o_last)
);
`default_nettype wire

// ===== test/iff_checker.sv =====
// checker for integer_field_formatter_unit: predicts the characters of each item
// and compares them with the result strobes; depends on the port list of the block only
`timescale 1ns / 100ps
module iff_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_mode,
    input  logic [63:0] i_value,
    input  logic [1:0]  i_size_mode,
    input  logic [6:0]  i_field_width,
    input  logic [5:0]  i_min_digits,
    input  logic        i_has_precision,
    input  logic        i_left_justify,
    input  logic        i_plus_sign,
    input  logic        i_space_sign,
    input  logic        i_alt_form,
    input  logic        i_zero_pad,
    input  logic        o_valid,
    input  logic [7:0]  o_out_char,
    input  logic        o_last,
    output int          fail_count,
    output int          chars_pending
);
    localparam int FIELD_MAX = 64;

    logic [8:0] expected_chars[$];

    function automatic int format_field(
        input logic [2:0] mode, input logic [63:0] raw, input logic [1:0] size,
        input logic [6:0] width_in, input logic [5:0] prec, input logic has_prec,
        input logic left, input logic plus, input logic space, input logic alt_in,
        input logic zpad_in, output logic [7:0] chars[FIELD_MAX]);
        logic [63:0] mag, v, low;
        logic [6:0] base;
        logic upper, neg, signed_kind, alt, zpad;
        logic [7:0] sign_ch, dig[24];
        logic [63:0] d;
        int nd, pz, body, pad, n, width, prefix, k;
        base = 10; upper = 0; neg = 0; signed_kind = 0; sign_ch = 0;
        nd = 0; pz = 0; pad = 0; n = 0; prefix = 0; alt = alt_in;
        if (mode > 3'd5) mode = 3'd1;
        if (mode == 3'd0) begin
            signed_kind = 1;
            if (size == 2'd2) begin
                neg = raw[63];
                mag = neg ? 64'd0 - raw : raw;
            end else begin
                low = {32'd0, raw[31:0]};
                neg = low[31];
                mag = neg ? 64'h1_0000_0000 - low : low;
            end
        end else if (mode == 3'd5) begin
            signed_kind = 1; mag = raw; base = 16; alt = 1;
        end else begin
            if (size == 2'd2) mag = raw;
            else if (size == 2'd1) mag = {48'd0, raw[15:0]};
            else mag = {32'd0, raw[31:0]};
            if (mode == 3'd2) base = 8;
            else if (mode == 3'd3) base = 16;
            else if (mode == 3'd4) begin
                base = 16; upper = 1;
            end
        end
        if (signed_kind) begin
            if (neg) sign_ch = "-";
            else if (plus) sign_ch = "+";
            else if (space) sign_ch = " ";
        end
        if (!(mag == 0 && has_prec && prec == 0)) begin
            v = mag;
            do begin
                d = v % base;
                dig[nd] = (d < 10) ? 8'h30 + d[7:0] : (upper ? 8'h41 : 8'h61) + d[7:0] - 8'd10;
                nd++;
                v = v / base;
            end while (v != 0 && nd < 24);
        end
        if (has_prec && prec > nd) pz = prec - nd;
        if (base == 8 && alt && pz == 0 && (mag != 0 || nd == 0)) pz = 1;
        if (base == 16 && alt && mag != 0) prefix = 2;
        body = (sign_ch != 0 ? 1 : 0) + prefix + pz + nd;
        if (body > FIELD_MAX) begin
            pz -= body - FIELD_MAX;
            body = FIELD_MAX;
        end
        width = (width_in > FIELD_MAX) ? FIELD_MAX : width_in;
        if (width > body) pad = width - body;
        zpad = zpad_in && !has_prec && !left;
        if (!left && !zpad) for (k = 0; k < pad; k++) chars[n++] = " ";
        if (sign_ch != 0) chars[n++] = sign_ch;
        if (prefix != 0) begin
            chars[n++] = "0";
            chars[n++] = upper ? "X" : "x";
        end
        if (zpad) for (k = 0; k < pad; k++) chars[n++] = "0";
        for (k = 0; k < pz; k++) chars[n++] = "0";
        for (k = nd - 1; k >= 0; k--) chars[n++] = dig[k];
        if (left) for (k = 0; k < pad; k++) chars[n++] = " ";
        return n;
    endfunction

    assign chars_pending = expected_chars.size();

    always @(posedge i_clk) begin
        logic [7:0] field[FIELD_MAX];
        logic [8:0] want;
        int cnt;
        if (!i_rst_n) begin
            fail_count <= 0;
        end else begin
            if (o_valid) begin
                if (expected_chars.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected char %h last %b", o_out_char, o_last);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_chars.pop_front();
                    if (want != {o_out_char, o_last}) begin
                        if (fail_count < 10)
                            $display("char exp %h last %b, got %h last %b",
                                     want[8:1], want[0], o_out_char, o_last);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                cnt = format_field(i_mode, i_value, i_size_mode, i_field_width,
                                   i_min_digits, i_has_precision, i_left_justify,
                                   i_plus_sign, i_space_sign, i_alt_form, i_zero_pad, field);
                for (int k = 0; k < cnt; k++)
                    expected_chars.push_back({field[k], k == cnt - 1});
            end
        end
    end
endmodule

// ===== test/tb_integer_field_formatter_unit.sv =====
// top of the integer_field_formatter_unit testbench: clock, reset, directed and random items
// depends on iff_pkg, integer_field_formatter_unit and iff_checker
`timescale 1ns / 100ps
module tb_integer_field_formatter_unit;
    import iff_pkg::*;

    typedef struct {
        logic [2:0]  mode;
        logic [63:0] value;
        logic [1:0]  size;
        logic [6:0]  width;
        logic [5:0]  prec;
        logic [5:0]  flags;  // has_prec, left, plus, space, alt, zero
    } fmt_req_t;

    logic i_clk = 0, i_rst_n = 0, start = 0, busy;
    logic [2:0] i_mode = 0;
    logic [63:0] i_value = 0;
    logic [1:0] i_size_mode = 0;
    logic [6:0] i_field_width = 0;
    logic [5:0] i_min_digits = 0;
    logic i_has_precision = 0, i_left_justify = 0, i_plus_sign = 0;
    logic i_space_sign = 0, i_alt_form = 0, i_zero_pad = 0;
    logic o_valid, o_last;
    logic [7:0] o_out_char;
    int fail_count, chars_pending;

    integer_field_formatter_unit dut (.*);
    iff_checker chk (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("integer_field_formatter_unit: mismatch");
        $finish;
    end

    task automatic send_item(input fmt_req_t r, input bit burst);
        int gap;
        i_mode <= r.mode;
        i_value <= r.value;
        i_size_mode <= r.size;
        i_field_width <= r.width;
        i_min_digits <= r.prec;
        {i_has_precision, i_left_justify, i_plus_sign, i_space_sign, i_alt_form,
         i_zero_pad} <= r.flags;
        start <= 1;
        do @(posedge i_clk); while (busy);
        gap = burst ? 0 : ($urandom_range(0, 9) < 7 ? $urandom_range(1, 3)
                                                   : $urandom_range(4, 40));
        if (gap > 0) begin
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 64'($urandom_range(0, 20));
            1: return 64'hFFFF_FFFF_FFFF_FFFF;
            2: return {32'd0, 1'b1, 31'd0} - 64'($urandom_range(0, 2));
            3: return {1'b1, 63'd0} - 64'($urandom_range(0, 2));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        fmt_req_t r;
        fmt_req_t directed[$];
        bit burst;
        int idx;
        directed = '{
            '{MODE_SDEC, 64'h8000_0000, 2'd0, 7'd0, 6'd0, 6'b000000},
            '{MODE_SDEC, 64'h8000_0000_0000_0000, SIZE_LONG, 7'd30, 6'd0, 6'b010000},
            '{MODE_SDEC, 64'h1234, SIZE_SHORT, 7'd10, 6'd0, 6'b001001},
            '{MODE_SDEC, 64'd42, 2'd3, 7'd8, 6'd0, 6'b000101},
            '{MODE_UDEC, 64'hFFFF_FFFF_FFFF_FFFF, SIZE_LONG, 7'd127, 6'd0, 6'b000000},
            '{MODE_UDEC, 64'h1_2345_FFFF, SIZE_SHORT, 7'd0, 6'd0, 6'b000000},
            '{3'd6, 64'd7, 2'd0, 7'd3, 6'd0, 6'b000000},
            '{3'd7, 64'd9, 2'd0, 7'd3, 6'd5, 6'b100000},
            '{MODE_OCT, 64'd8, 2'd0, 7'd0, 6'd0, 6'b000010},
            '{MODE_OCT, 64'd0, 2'd0, 7'd0, 6'd0, 6'b100010},
            '{MODE_OCT, 64'd8, 2'd0, 7'd0, 6'd4, 6'b100010},
            '{MODE_OCT, 64'hFFFF_FFFF_FFFF_FFFF, SIZE_LONG, 7'd64, 6'd63, 6'b100010},
            '{MODE_HEXL, 64'hDEAD_BEEF, 2'd0, 7'd12, 6'd0, 6'b000011},
            '{MODE_HEXU, 64'hABCD_EF01, SIZE_LONG, 7'd12, 6'd0, 6'b010010},
            '{MODE_HEXL, 64'd0, 2'd0, 7'd5, 6'd0, 6'b000010},
            '{MODE_HEXU, 64'd0, 2'd0, 7'd0, 6'd0, 6'b100000},
            '{MODE_SDEC, 64'd0, 2'd0, 7'd0, 6'd0, 6'b101000},
            '{MODE_PTR, 64'd0, 2'd0, 7'd0, 6'd0, 6'b000000},
            '{MODE_PTR, 64'hFFFF_FFFF_FFFF_FFFF, SIZE_SHORT, 7'd20, 6'd0, 6'b001001},
            '{MODE_PTR, 64'h1000, 2'd0, 7'd70, 6'd63, 6'b110100},
            '{MODE_SDEC, 64'hFFFF_FFFF, 2'd0, 7'd100, 6'd63, 6'b100000},
            '{MODE_UDEC, 64'd5, 2'd0, 7'd6, 6'd3, 6'b100001}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (directed[k]) send_item(directed[k], 0);
        burst = 0;
        for (idx = 0; idx < 258; idx++) begin
            if ($urandom_range(0, 19) == 0) burst = !burst;
            r.mode = 3'($urandom_range(0, 7));
            r.value = pick_value();
            r.size = 2'($urandom_range(0, 3));
            r.width = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(0, 24));
            r.prec = 6'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, 12));
            r.flags = 6'($urandom_range(0, 63));
            send_item(r, burst);
        end
        start <= 0;
        @(posedge i_clk);
        while (busy || chars_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("integer_field_formatter_unit: match");
        else
            $display("integer_field_formatter_unit: mismatch");
        $finish;
    end
endmodule
